// ----- src/afsm_pkg.sv -----
// Shared constants and helpers for the stripe merge core.
// SHA-1 initial values, round constants and rotate helpers; no dependencies.
`default_nettype none
package afsm_pkg;

    localparam int CHUNK_BYTES = 20;
    localparam int INDEX_BYTES = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [7:0] REG_BLOCK_BYTES  = 8'd0;
    localparam logic [7:0] REG_STRIPE_COUNT = 8'd1;

    typedef logic [31:0] t_word;

    function automatic t_word rotl1(input t_word x);
        return {x[30:0], x[31]};
    endfunction

    function automatic t_word rotl5(input t_word x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic t_word rotl30(input t_word x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage
`default_nettype wire

// ----- src/af_stripe_merge_sha1_core.sv -----
// Anti-forensic stripe merge: XORs split material into a mix buffer and diffuses it
// with one shared SHA-1 round unit between stripes. Depends on afsm_pkg.
`default_nettype none
//  channel | signals                                          | direction
//  input   | i_valid, o_ready, i_data_byte                    | in
//  output  | o_valid, i_ready, o_key_byte, o_last_byte        | out
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// An item that does not end a stripe is handled as a buffer read, then XOR and write.
// At the end of a stripe other than the last, each chunk of up to 20 bytes is loaded
// into the message schedule, run through 80 rounds of the single SHA-1 round unit,
// finalized and written back to the buffer one byte at a time.
// Reset clears all buffer valid bits at once, so no clearing pass is needed.
// A result waiting in the output register stalls only an item of the last stripe.
// Register writes are taken only while idle and take priority over an input item.
module af_stripe_merge_sha1_core #(
    parameter int MAX_BLOCK_BYTES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_key_byte,
    output logic             o_last_byte,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_BLOCK_BYTES);
    localparam int LW = $clog2(MAX_BLOCK_BYTES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]   r_state;
    logic [8:0]   r_block_bytes;
    logic [15:0]  r_stripe_count;
    logic [AW-1:0] r_byte_pos;
    logic [15:0]  r_stripe_pos;
    logic [3:0]   r_chunk;
    logic [LW-1:0] r_base;
    logic [6:0]   r_cnt;
    logic [7:0]   r_in_byte;
    logic         r_out_valid;
    logic [7:0]   r_key;
    logic         r_last;

    logic [7:0]   r_mem [MAX_BLOCK_BYTES];
    logic [MAX_BLOCK_BYTES-1:0] r_valid;
    logic [7:0]   r_rd_data;
    logic         r_rd_vld;

    afsm_pkg::t_word r_sr [16];
    afsm_pkg::t_word r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_dig;

    logic [LW-1:0] len;
    logic [16:0]  cnt_eff;
    logic         last_stripe;
    logic         end_of_stripe;
    logic [LW-1:0] rem;
    logic [4:0]   clen;
    logic [7:0]   bits_lo;
    logic [6:0]   ld_j;
    logic [7:0]   ld_byte;
    logic [7:0]   rd_byte;
    logic [7:0]   x_byte;
    logic [9:0]   ld_addr_w;
    logic [9:0]   wr_addr_w;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic         mem_we;
    logic         accept;
    logic         cfg_hit;
    logic         restart;
    logic         out_blocked;
    afsm_pkg::t_word f_val, k_val, t_sum, w_new;

    always_comb begin
        if (r_block_bytes == 9'd0) begin
            len = LW'(1);
        end else if (10'(r_block_bytes) > 10'(MAX_BLOCK_BYTES)) begin
            len = LW'(MAX_BLOCK_BYTES);
        end else begin
            len = LW'(r_block_bytes);
        end
    end

    assign cnt_eff       = (r_stripe_count == 16'd0) ? 17'd1 : {1'b0, r_stripe_count};
    assign last_stripe   = ({1'b0, r_stripe_pos} + 17'd1) >= cnt_eff;
    assign end_of_stripe = (LW'(r_byte_pos) + LW'(1)) >= len;
    assign rem           = len - r_base;
    assign clen          = (rem > LW'(afsm_pkg::CHUNK_BYTES)) ? 5'(afsm_pkg::CHUNK_BYTES)
                                                               : rem[4:0];
    assign bits_lo       = {clen + 5'(afsm_pkg::INDEX_BYTES), 3'b000};

    assign rd_byte = r_rd_vld ? r_rd_data : 8'd0;
    assign x_byte  = r_in_byte ^ rd_byte;

    // Message byte j of the padded block: index word, chunk, pad, bit length.
    assign ld_j = r_cnt - 7'd1;
    always_comb begin
        if (ld_j < 7'd3) begin
            ld_byte = 8'd0;
        end else if (ld_j == 7'd3) begin
            ld_byte = {4'd0, r_chunk};
        end else if (ld_j < 7'(clen) + 7'd4) begin
            ld_byte = rd_byte;
        end else if (ld_j == 7'(clen) + 7'd4) begin
            ld_byte = afsm_pkg::PAD_BYTE;
        end else if (ld_j == 7'd63) begin
            ld_byte = bits_lo;
        end else begin
            ld_byte = 8'd0;
        end
    end

    assign ld_addr_w = 10'(r_base) + 10'(r_cnt) - 10'd4;
    assign wr_addr_w = 10'(r_base) + 10'(r_cnt);
    assign rd_addr   = (r_state == S_LOAD) ? ld_addr_w[AW-1:0] : r_byte_pos;
    assign wr_addr   = (r_state == S_WRITE) ? wr_addr_w[AW-1:0] : r_byte_pos;

    assign out_blocked = r_out_valid && !i_ready;
    assign mem_we = ((r_state == S_READ) && !last_stripe) || (r_state == S_WRITE);

    always_comb begin
        if (r_cnt < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = afsm_pkg::K0;
        end else if (r_cnt < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = afsm_pkg::K1;
        end else if (r_cnt < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = afsm_pkg::K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = afsm_pkg::K3;
        end
    end

    assign t_sum = afsm_pkg::rotl5(r_a) + f_val + r_e + k_val + r_sr[0];
    assign w_new = afsm_pkg::rotl1(r_sr[13] ^ r_sr[8] ^ r_sr[2] ^ r_sr[0]);

    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign cfg_hit     = i_cfg_valid && o_cfg_ready &&
                         ((i_cfg_index == afsm_pkg::REG_BLOCK_BYTES) ||
                          (i_cfg_index == afsm_pkg::REG_STRIPE_COUNT));
    assign restart     = cfg_hit ||
                         ((r_state == S_READ) && last_stripe && !out_blocked && end_of_stripe);

    assign o_valid     = r_out_valid;
    assign o_key_byte  = r_key;
    assign o_last_byte = r_last;

    // Buffer memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= (r_state == S_WRITE) ? r_dig[159:152] : x_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[rd_addr];
            if (restart) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_block_bytes  <= 9'd32;
            r_stripe_count <= 16'd4000;
            r_byte_pos     <= '0;
            r_stripe_pos   <= '0;
            r_chunk        <= '0;
            r_base         <= '0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_byte <= i_data_byte;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    if (last_stripe) begin
                        if (!out_blocked) begin
                            r_out_valid <= 1'b1;
                            r_key       <= x_byte;
                            r_last      <= end_of_stripe;
                            r_state     <= S_IDLE;
                            if (end_of_stripe) begin
                                r_byte_pos   <= '0;
                                r_stripe_pos <= '0;
                            end else begin
                                r_byte_pos <= r_byte_pos + AW'(1);
                            end
                        end
                    end else if (end_of_stripe) begin
                        r_base  <= '0;
                        r_chunk <= '0;
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_byte_pos <= r_byte_pos + AW'(1);
                        r_state    <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    if (r_cnt != 7'd0) begin
                        for (int i = 0; i < 15; i++) begin
                            r_sr[i] <= {r_sr[i][23:0], r_sr[i+1][31:24]};
                        end
                        r_sr[15] <= {r_sr[15][23:0], ld_byte};
                    end
                    if (r_cnt == 7'd64) begin
                        r_a     <= afsm_pkg::H0;
                        r_b     <= afsm_pkg::H1;
                        r_c     <= afsm_pkg::H2;
                        r_d     <= afsm_pkg::H3;
                        r_e     <= afsm_pkg::H4;
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_sr[i] <= r_sr[i+1];
                    end
                    r_sr[15] <= w_new;
                    r_e <= r_d;
                    r_d <= r_c;
                    r_c <= afsm_pkg::rotl30(r_b);
                    r_b <= r_a;
                    r_a <= t_sum;
                    if (r_cnt == 7'd79) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_FIN: begin
                    r_dig   <= {afsm_pkg::H0 + r_a, afsm_pkg::H1 + r_b, afsm_pkg::H2 + r_c,
                                afsm_pkg::H3 + r_d, afsm_pkg::H4 + r_e};
                    r_cnt   <= '0;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_dig <= {r_dig[151:0], 8'd0};
                    if (r_cnt == 7'(clen) - 7'd1) begin
                        r_base  <= r_base + LW'(clen);
                        r_chunk <= r_chunk + 4'd1;
                        r_cnt   <= '0;
                        if (r_base + LW'(clen) >= len) begin
                            r_byte_pos   <= '0;
                            r_stripe_pos <= r_stripe_pos + 16'd1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // A register write restarts the merge.
            if (cfg_hit) begin
                if (i_cfg_index == afsm_pkg::REG_BLOCK_BYTES) begin
                    r_block_bytes <= i_cfg_data[8:0];
                end else begin
                    r_stripe_count <= i_cfg_data;
                end
                r_byte_pos   <= '0;
                r_stripe_pos <= '0;
                r_chunk      <= '0;
                r_state      <= S_IDLE;
            end
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_byte_pos) < len))
        else $error("byte position beyond block length");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_cnt <= 7'd79))
        else $error("round counter overran");

    a_load_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_base < len))
        else $error("chunk base past end of buffer");

    a_result_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> ($past(r_state) == S_READ))
        else $error("result produced outside the last stripe");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for af_stripe_merge_sha1_core: stripe XOR merge with SHA-1 diffusion.
// A scoreboard class predicts each key byte; depends on afsm_pkg and the core RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] key;
    logic       last;
} t_key_exp;

class key_merge_sb;
    logic [8:0]  blk_reg;
    logic [15:0] cnt_reg;
    logic [7:0]  mix [256];
    int          bpos;
    int          spos;
    t_key_exp    keys_due [$];
    int          errors;

    function void restart();
        foreach (mix[i]) mix[i] = 8'h00;
        bpos = 0;
        spos = 0;
    endfunction

    function void do_reset();
        blk_reg = 9'd32;
        cnt_reg = 16'd4000;
        errors  = 0;
        restart();
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] d);
        if (idx == afsm_pkg::REG_BLOCK_BYTES) begin
            blk_reg = d[8:0];
            restart();
        end else if (idx == afsm_pkg::REG_STRIPE_COUNT) begin
            cnt_reg = d;
            restart();
        end
    endfunction

    function logic [31:0] rl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function int stripe_len();
        if (blk_reg == 0) return 1;
        if (blk_reg > 256) return 256;
        return blk_reg;
    endfunction

    // Each chunk becomes SHA-1(be32(chunk index) || chunk), cut to the chunk length.
    function void diffuse(int len);
        logic [7:0]  msg [64];
        logic [31:0] w [16];
        logic [31:0] h [5];
        logic [31:0] a, b, c, d, e, f, k, t32;
        int base, clen, chunk, bits;
        base = 0;
        chunk = 0;
        while (base < len) begin
            clen = (len - base > afsm_pkg::CHUNK_BYTES) ? afsm_pkg::CHUNK_BYTES : len - base;
            foreach (msg[j]) msg[j] = 8'h00;
            msg[3] = chunk[7:0];
            for (int j = 0; j < clen; j++) msg[afsm_pkg::INDEX_BYTES + j] = mix[base + j];
            msg[afsm_pkg::INDEX_BYTES + clen] = afsm_pkg::PAD_BYTE;
            bits = (afsm_pkg::INDEX_BYTES + clen) * 8;
            msg[62] = bits[15:8];
            msg[63] = bits[7:0];
            for (int j = 0; j < 16; j++)
                w[j] = {msg[4*j], msg[4*j+1], msg[4*j+2], msg[4*j+3]};
            h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
            a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
            for (int t = 0; t < 80; t++) begin
                if (t >= 16)
                    w[t%16] = rl(w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16], 1);
                if (t < 20) begin
                    f = (b & c) | (~b & d); k = 32'h5A827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d; k = 32'h6ED9EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d; k = 32'hCA62C1D6;
                end
                t32 = rl(a, 5) + f + e + k + w[t%16];
                e = d; d = c; c = rl(b, 30); b = a; a = t32;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
            for (int j = 0; j < clen; j++)
                mix[base + j] = 8'(h[j/4] >> (24 - 8 * (j % 4)));
            base += clen;
            chunk = (chunk + 1) % 16;
        end
    endfunction

    function void note_byte(logic [7:0] din);
        int len, cnt, pos;
        logic [7:0] x;
        logic eos;
        t_key_exp ex;
        len = stripe_len();
        cnt = (cnt_reg == 0) ? 1 : cnt_reg;
        pos = bpos % len;
        x   = din ^ mix[pos];
        eos = (pos + 1 >= len);
        if (spos + 1 >= cnt) begin
            ex.key  = x;
            ex.last = eos;
            keys_due.push_back(ex);
            if (eos) restart();
            else bpos = pos + 1;
        end else begin
            mix[pos] = x;
            if (eos) begin
                diffuse(len);
                bpos = 0;
                spos = (spos + 1) % 65536;
            end else begin
                bpos = pos + 1;
            end
        end
    endfunction

    function void check_key(logic [7:0] key, logic last);
        t_key_exp ex;
        if (keys_due.size() == 0) begin
            $error("unexpected key byte %02h last %0d", key, last);
            errors++;
            return;
        end
        ex = keys_due.pop_front();
        if (key !== ex.key) begin
            $error("key_byte: expected %02h, actual %02h", ex.key, key);
            errors++;
        end
        if (last !== ex.last) begin
            $error("last_byte: expected %0d, actual %0d", ex.last, last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int SETTLE_CYCLES = 3000;
    localparam int QUIET_LIMIT   = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_key_byte;
    logic        o_last_byte;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = 8'h00;
    logic [15:0] i_cfg_data = 16'h0000;

    key_merge_sb merge_sb = new();
    bit          idling = 1'b1;
    int          bytes_sent = 0;
    int          quiet = 0;

    af_stripe_merge_sha1_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Output side: check every accepted key byte, stall in random bursts while idling is set.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) merge_sb.check_key(o_key_byte, o_last_byte);
    end

    initial begin
        int n;
        @(posedge i_clk);
        while (1) begin
            i_ready <= 1'b1;
            n = $urandom_range(1, 40);
            repeat (n) @(posedge i_clk);
            if (idling && $urandom_range(0, 1)) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("af_stripe_merge_sha1_core: mismatch");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] d);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        merge_sb.note_byte(d);
        bytes_sent++;
    endtask

    // Wait for every expected key byte, then for any diffusion still running.
    task automatic settle();
        i_valid <= 1'b0;
        while (merge_sb.keys_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        merge_sb.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_merge(input logic [15:0] blk, input logic [15:0] cnt, input int n);
        settle();
        write_cfg(afsm_pkg::REG_BLOCK_BYTES, blk);
        write_cfg(afsm_pkg::REG_STRIPE_COUNT, cnt);
        for (int i = 0; i < n; i++) send_byte($urandom_range(0, 255));
    endtask

    initial begin
        int blk, cnt, n;
        merge_sb.do_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: far from the last stripe, so nothing comes out.
        send_byte(8'h00);
        send_byte(8'hFF);
        for (int i = 0; i < 6; i++) send_byte($urandom_range(0, 255));

        // Zero length and zero count both act as one: every byte is a whole key.
        settle();
        write_cfg(afsm_pkg::REG_BLOCK_BYTES, 16'h0000);
        write_cfg(afsm_pkg::REG_STRIPE_COUNT, 16'h0000);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);

        run_merge(16'd3, 16'd2, 12);
        run_merge(16'd41, 16'd3, 123);
        // Exact maximum length with the largest count: no key comes out.
        run_merge(16'd256, 16'hFFFF, 5);
        // An unknown register index leaves the merge where it was.
        settle();
        write_cfg(8'hFF, 16'hFFFF);
        write_cfg(8'd2, 16'h0000);
        for (int i = 0; i < 4; i++) send_byte($urandom_range(0, 255));
        // Oversized length saturates at 256 bytes, one full diffusion pass.
        run_merge(16'hFFFF, 16'd2, 512);

        while (bytes_sent < 900) begin
            if (bytes_sent > 750) idling = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: blk = $urandom_range(1, 24);
                6, 7, 8:          blk = $urandom_range(25, 64);
                default:          blk = $urandom_range(65, 160);
            endcase
            cnt = $urandom_range(1, 4);
            n = blk * cnt * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) n += $urandom_range(1, blk * cnt);
            if (bytes_sent + n > 950) n = 950 - bytes_sent;
            run_merge(blk[15:0], {$urandom_range(0, 1) ? 7'h00 : 7'h7F, 9'h000} | 16'(cnt)
                      & 16'hFFFF, 0);
            // The count is then written again without the upper bits.
            settle();
            write_cfg(afsm_pkg::REG_STRIPE_COUNT, 16'(cnt));
            if ($urandom_range(0, 3) == 0) write_cfg(8'($urandom_range(2, 255)),
                                                     16'($urandom_range(0, 65535)));
            for (int i = 0; i < n; i++) send_byte($urandom_range(0, 255));
        end

        i_valid <= 1'b0;
        while (merge_sb.keys_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (merge_sb.errors == 0 && merge_sb.keys_due.size() == 0)
            $display("af_stripe_merge_sha1_core: match");
        else
            $display("af_stripe_merge_sha1_core: mismatch");
        $finish;
    end
endmodule
